FILE: hw/rtl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = 11;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int CELL_W     = 16;

   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] GLYPH_CODE   = 8'h02;
   localparam logic [7:0] ATTR_RESET   = 8'd15;

   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUT,
      S_COPY,
      S_COPY_END,
      S_BLANK,
      S_CLEAR,
      S_STORE,
      S_READ,
      S_EMIT
   } state_type;

   function automatic logic [7:0] glyph_byte(input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = 8'hF0;
         2'd1:    b = 8'h9F;
         2'd2:    b = 8'h8D;
         default: b = 8'hBF;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/text_console_writer.sv
// Text console writer: cell store, cursor, scroll, clear, cell read and serial echo.
//
// A text console of ROWS x COLUMNS cells held in one single-port-write RAM, with one
// result register on the response side. The glyph code 2 echoes four bytes, one per
// result; every other item gives one result, and each result waits for a free result
// slot. A clear writes blanks to every cell. A newline or wrap on the last row scrolls:
// one sweep copies CELL_COUNT - COLUMNS cells one row up (one RAM read and one write
// per cycle) and a second sweep blanks the bottom row. These sweeps, set by the one
// RAM write port, dominate the cost; the block takes no new item until the current
// one is done, and takes the next one from the edge after the final result is loaded.
// Cells are undefined until written or cleared; there is no clearing pass after reset.
module text_console_writer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0] req_cell_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_serial_valid,
   output logic [7:0]                rsp_serial_byte,
   output logic [tcw_pkg::ROW_W-1:0] rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0] rsp_cursor_col,
   output logic [7:0]                rsp_cell_char,
   output logic [7:0]                rsp_cell_attr,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_data
);

   import tcw_pkg::*;

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         char_ff, char_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [7:0]         attr_ff;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]         echo_k_ff, echo_k_in;
   logic               pend_store_ff, pend_store_in;
   logic               copy_wr_ff, copy_wr_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_serial_valid_ff, rsp_serial_valid_in;
   logic [7:0]         rsp_serial_byte_ff, rsp_serial_byte_in;
   logic [ROW_W-1:0]   rsp_cursor_row_ff, rsp_cursor_row_in;
   logic [COL_W-1:0]   rsp_cursor_col_ff, rsp_cursor_col_in;
   logic [7:0]         rsp_cell_char_ff, rsp_cell_char_in;
   logic [7:0]         rsp_cell_attr_ff, rsp_cell_attr_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;

   logic [ADDR_W-1:0]  cursor_addr;
   logic               sweep_last;
   logic               slot_free;
   logic               is_put;
   logic               is_glyph;
   logic               emit_last;

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_cells (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign cursor_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign sweep_last  = (cnt_ff == ADDR_W'(CELL_COUNT - 1));
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign is_put      = (kind_ff == KIND_PUT);
   assign is_glyph    = is_put && (char_ff == GLYPH_CODE);
   assign emit_last   = !is_glyph || (echo_k_ff == 2'd3);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in            = state_ff;
      kind_in             = kind_ff;
      char_in             = char_ff;
      idx_in              = idx_ff;
      row_in              = row_ff;
      col_in              = col_ff;
      cnt_in              = cnt_ff;
      echo_k_in           = echo_k_ff;
      pend_store_in       = pend_store_ff;
      copy_wr_in          = copy_wr_ff;
      wr_addr_in          = wr_addr_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_serial_valid_in = rsp_serial_valid_ff;
      rsp_serial_byte_in  = rsp_serial_byte_ff;
      rsp_cursor_row_in   = rsp_cursor_row_ff;
      rsp_cursor_col_in   = rsp_cursor_col_ff;
      rsp_cell_char_in    = rsp_cell_char_ff;
      rsp_cell_attr_in    = rsp_cell_attr_ff;
      rsp_last_in         = rsp_last_ff;
      ram_we              = 1'b0;
      ram_waddr           = cnt_ff;
      ram_wdata           = {attr_ff, BLANK_CHAR};
      ram_raddr           = (state_ff == S_COPY) ? cnt_ff : idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               char_in   = req_char_code;
               idx_in    = req_cell_index;
               echo_k_in = 2'd0;
               case (req_kind)
                  KIND_PUT:   state_in = S_PUT;
                  KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  KIND_READ:  state_in = S_READ;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_PUT: begin
            if (char_ff == NEWLINE_CHAR || col_ff >= COL_W'(COLUMNS)) begin
               pend_store_in = (char_ff != NEWLINE_CHAR);
               col_in        = '0;
               if (row_ff < ROW_W'(ROWS - 1)) begin
                  row_in   = row_ff + 1'b1;
                  state_in = (char_ff != NEWLINE_CHAR) ? S_STORE : S_EMIT;
               end else begin
                  cnt_in     = ADDR_W'(COLUMNS);
                  copy_wr_in = 1'b0;
                  state_in   = S_COPY;
               end
            end else begin
               state_in = S_STORE;
            end
         end
         S_COPY: begin
            ram_we     = copy_wr_ff;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            copy_wr_in = 1'b1;
            wr_addr_in = cnt_ff - ADDR_W'(COLUMNS);
            cnt_in     = cnt_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_COPY_END;
            end
         end
         S_COPY_END: begin
            ram_we     = 1'b1;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            copy_wr_in = 1'b0;
            cnt_in     = ADDR_W'(CELL_COUNT - COLUMNS);
            state_in   = S_BLANK;
         end
         S_BLANK: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (sweep_last) begin
               state_in = pend_store_ff ? S_STORE : S_EMIT;
            end
         end
         S_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_EMIT;
            end
         end
         S_STORE: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_addr;
            ram_wdata = {attr_ff, char_ff};
            col_in    = col_ff + 1'b1;
            state_in  = S_EMIT;
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_serial_valid_in = is_put;
               rsp_serial_byte_in  = !is_put ? 8'd0 :
                                     is_glyph ? glyph_byte(echo_k_ff) : char_ff;
               rsp_cursor_row_in   = row_ff;
               rsp_cursor_col_in   = col_ff;
               if (kind_ff == KIND_READ && idx_ff < ADDR_W'(CELL_COUNT)) begin
                  rsp_cell_char_in = ram_rdata[7:0];
                  rsp_cell_attr_in = ram_rdata[15:8];
               end else begin
                  rsp_cell_char_in = 8'd0;
                  rsp_cell_attr_in = 8'd0;
               end
               rsp_last_in = emit_last;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  echo_k_in = echo_k_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_ff        <= '0;
         col_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         rsp_valid_ff  <= 1'b0;
         copy_wr_ff    <= 1'b0;
         pend_store_ff <= 1'b0;
         cnt_ff        <= '0;
         echo_k_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rsp_valid_ff  <= rsp_valid_in;
         copy_wr_ff    <= copy_wr_in;
         pend_store_ff <= pend_store_in;
         cnt_ff        <= cnt_in;
         echo_k_ff     <= echo_k_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff             <= kind_in;
      char_ff             <= char_in;
      idx_ff              <= idx_in;
      wr_addr_ff          <= wr_addr_in;
      rsp_serial_valid_ff <= rsp_serial_valid_in;
      rsp_serial_byte_ff  <= rsp_serial_byte_in;
      rsp_cursor_row_ff   <= rsp_cursor_row_in;
      rsp_cursor_col_ff   <= rsp_cursor_col_in;
      rsp_cell_char_ff    <= rsp_cell_char_in;
      rsp_cell_attr_ff    <= rsp_cell_attr_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_serial_valid = rsp_serial_valid_ff;
   assign rsp_serial_byte  = rsp_serial_byte_ff;
   assign rsp_cursor_row   = rsp_cursor_row_ff;
   assign rsp_cursor_col   = rsp_cursor_col_ff;
   assign rsp_cell_char    = rsp_cell_char_ff;
   assign rsp_cell_attr    = rsp_cell_attr_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff < ROW_W'(ROWS)) && (col_ff <= COL_W'(COLUMNS)))
      else $error("cursor out of range");

   a_copy_target: assert property (@(posedge clock) disable iff (reset)
      ram_we && (state_ff == S_COPY || state_ff == S_COPY_END)
      |-> wr_addr_ff < ADDR_W'(CELL_COUNT - COLUMNS))
      else $error("scroll copy writes past the upper rows");

   a_put_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_PUT |=> state_ff == S_PUT)
      else $error("put transfer did not start the put sequence");

   a_partial_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_serial_valid)
      else $error("non-final result without an echo byte");
`endif

endmodule
